// ===== rtl/core/lkvc_pkg.sv =====
// shared types, constants and helpers of the lru key-value cache
package lkvc_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ADDR_W  = 3;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [WORD_W-1:0] MISS_VALUE = '1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic                     operation;
    logic signed [WORD_W-1:0] lookup_key;
    logic signed [WORD_W-1:0] store_value;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [WORD_W-1:0] read_value;
  } out_item_t;

  // written capacity of zero acts as one, above the entry count as the entry count
  function automatic logic [CNT_W-1:0] limit_capacity(input logic [CAP_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > 32'(ENTRIES)) begin
      r = CNT_W'(ENTRIES);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/lkvc_cell.sv =====
// one slot of the recency stack: holds a key/value pair, compares and shifts
module lkvc_cell (
  input  logic           clk_i,
  input  logic           shift_en_i,
  input  lkvc_pkg::word_t key_i,
  input  lkvc_pkg::word_t value_i,
  input  logic           slot_valid_i,
  input  lkvc_pkg::word_t search_key_i,
  output lkvc_pkg::word_t key_o,
  output lkvc_pkg::word_t value_o,
  output logic           match_o
);
  import lkvc_pkg::*;

  word_t key_q;
  word_t value_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  assign match_o = slot_valid_i && (key_q == search_key_i);
  assign key_o   = key_q;
  assign value_o = value_q;

endmodule

// ===== rtl/core/lru_key_value_cache_unit.sv =====
// top level of the lru key-value cache: control, cell chain and apb register
//
//   channel   direction  handshake                  beat
//   in        sink       in_valid_i / in_stall_o    in_item_t  (operation, key, value)
//   out       source     out_valid_o / out_stall_i  out_item_t (hit, read_value)
//   cfg       apb slave  psel/penable/pwrite/pready capacity at byte address 0
//
// an item is first accepted into the item register; then, in the busy state, every cell
// compares its key and the chain shifts toward the least recent end.
// a get stays in the busy state while the previous result sits stalled
// in the output register; a put never waits on the output side.
// reset empties the store through the fill count alone, with no clearing pass.
module lru_key_value_cache_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lkvc_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lkvc_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkvc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lkvc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic             state_q, state_d;
  in_item_t         item_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] cap_q, cap_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q;

  logic             in_accept;
  logic             cfg_write;
  logic             done;
  logic             hit;
  logic [IDX_W-1:0] hit_pos;
  word_t            hit_value;
  logic             do_shift;
  logic [CNT_W-1:0] shift_limit;
  word_t            head_value;

  word_t                key_chain   [ENTRIES];
  word_t                value_chain [ENTRIES];
  logic [ENTRIES-1:0]   match;

  assign in_accept = in_valid_i && !in_stall_o;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_CAPACITY) ? 32'(cap_q) : '0;

  // cell chain: cell 0 takes the new head, each other cell its neighbor
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    word_t key_in;
    word_t value_in;
    if (i == 0) begin : g_head
      assign key_in   = item_q.lookup_key;
      assign value_in = head_value;
    end else begin : g_body
      assign key_in   = key_chain[i-1];
      assign value_in = value_chain[i-1];
    end
    lkvc_cell u_cell (
      .clk_i        (clk_i),
      .shift_en_i   (do_shift && (CNT_W'(i) <= shift_limit)),
      .key_i        (key_in),
      .value_i      (value_in),
      .slot_valid_i (CNT_W'(i) < fill_q),
      .search_key_i (item_q.lookup_key),
      .key_o        (key_chain[i]),
      .value_o      (value_chain[i]),
      .match_o      (match[i])
    );
  end

  // at most one cell matches, keys never repeat
  always_comb begin
    hit       = |match;
    hit_pos   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_pos   = IDX_W'(i);
        hit_value = hit_value | value_chain[i];
      end
    end
  end

  assign done = !(item_q.operation == OP_GET && out_valid_q && out_stall_i);

  always_comb begin
    head_value  = (item_q.operation == OP_PUT) ? item_q.store_value : hit_value;
    do_shift    = 1'b0;
    shift_limit = '0;
    fill_d      = fill_q;
    if (state_q == ST_BUSY && done) begin
      if (hit) begin
        do_shift    = 1'b1;
        shift_limit = CNT_W'(hit_pos);
      end else if (item_q.operation == OP_PUT) begin
        do_shift = 1'b1;
        if (fill_q >= cap_q) begin
          // full: the least recent slot is shifted over
          shift_limit = cap_q - 1'b1;
          fill_d      = cap_q;
        end else begin
          shift_limit = fill_q;
          fill_d      = fill_q + 1'b1;
        end
      end
    end
    cap_d = cap_q;
    if (cfg_write && paddr[2] == REG_CAPACITY) begin
      cap_d = limit_capacity(pwdata[CAP_W-1:0]);
      if (fill_q > cap_d) begin
        fill_d = cap_d;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (done) begin
          state_d = ST_IDLE;
          if (item_q.operation == OP_GET) begin
            out_valid_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      cap_q       <= CNT_W'(ENTRIES);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_BUSY && done && item_q.operation == OP_GET) begin
      out_data_q.hit        <= hit;
      out_data_q.read_value <= hit ? hit_value : MISS_VALUE;
    end
  end

  assign in_stall_o  = (state_q == ST_BUSY);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_fill_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cap_q)
    else $error("fill count above capacity");

  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q != '0 && 32'(cap_q) <= 32'(ENTRIES))
    else $error("capacity out of range");

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_BUSY)
    else $error("accepted item not processed next cycle");

  a_get_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUSY && done && item_q.operation == OP_GET)
      |=> out_valid_q && out_data_q.hit == $past(hit))
    else $error("get result not presented");

endmodule

// ===== test/tb.sv =====
// self-checking testbench of the lru key-value cache unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned POOL_SIZE    = 40;
  localparam int unsigned PHASE_ITEMS  = 115;

  // shadow copy of the recency stack and the expected get results
  class lru_shadow;
    word_t       keys[ENTRIES];
    word_t       vals[ENTRIES];
    int unsigned fill;
    int unsigned cap;
    out_item_t   expected_reads[$];
    int unsigned accesses, reads, hits, evictions, checked, failures;

    function new();
      fill = 0;
      cap  = limit_of(16);
    endfunction

    function int unsigned limit_of(int unsigned raw);
      int unsigned v;
      v = raw & 32'h1f;
      if (v == 0) v = 1;
      if (v > ENTRIES) v = ENTRIES;
      return v;
    endfunction

    // capacity lowered below the fill drops the least recent entries at once
    function void set_capacity(int unsigned raw);
      cap = limit_of(raw);
      if (fill > cap) fill = cap;
    endfunction

    function void move_to_front(int unsigned pos, word_t k, word_t v);
      for (int i = pos; i > 0; i--) begin
        keys[i] = keys[i-1];
        vals[i] = vals[i-1];
      end
      keys[0] = k;
      vals[0] = v;
    endfunction

    function void note_access(in_item_t it);
      word_t       k, v;
      int unsigned pos;
      out_item_t   want;
      k   = it.lookup_key;
      v   = it.store_value;
      pos = fill;
      for (int i = 0; i < fill; i++) begin
        if (keys[i] == k) begin
          pos = i;
          break;
        end
      end
      accesses++;
      if (it.operation == OP_GET) begin
        reads++;
        if (pos < fill) begin
          hits++;
          want.hit        = 1'b1;
          want.read_value = vals[pos];
          move_to_front(pos, k, vals[pos]);
        end else begin
          want.hit        = 1'b0;
          want.read_value = MISS_VALUE;
        end
        expected_reads.push_back(want);
      end else if (pos < fill) begin
        move_to_front(pos, k, v);
      end else if (fill >= cap) begin
        evictions++;
        move_to_front(cap - 1, k, v);
        fill = cap;
      end else begin
        move_to_front(fill, k, v);
        fill++;
      end
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      failures++;
      if (failures <= 10)
        $display("mismatch %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_read(out_item_t got);
      out_item_t want;
      if (expected_reads.size() == 0) begin
        report("unexpected result beat", '0, got.read_value);
        return;
      end
      want = expected_reads.pop_front();
      checked++;
      if (got.hit !== want.hit) report("hit", 32'(want.hit), 32'(got.hit));
      if (got.read_value !== want.read_value)
        report("read_value", want.read_value, got.read_value);
    endfunction

    function void check_capacity(logic [31:0] got);
      if (got !== 32'(cap)) report("capacity readback", 32'(cap), got);
    endfunction

    function int unsigned pending();
      return expected_reads.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  in_item_t    in_data    = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  out_item_t   out_data;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;

  lru_shadow   sb = new();
  bit          sender_gaps   = 1'b1;
  bit          receiver_gaps = 1'b1;
  bit          hold_request  = 1'b0;
  int unsigned cfg_writes    = 0;
  word_t       key_pool[POOL_SIZE];

  lru_key_value_cache_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic in_item_t mk(logic op, word_t k, word_t v);
    in_item_t it;
    it.operation   = op;
    it.lookup_key  = k;
    it.store_value = v;
    return it;
  endfunction

  // mostly keys from a small pool so that gets hit and puts update
  function automatic in_item_t rand_access(int unsigned pool_n);
    word_t k;
    if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, pool_n - 1)];
    else k = $urandom;
    return mk($urandom_range(0, 1) ? OP_PUT : OP_GET, k, $urandom);
  endfunction

  task automatic send_access(in_item_t it);
    int unsigned gap;
    gap = sender_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_access(it);
  endtask

  task automatic apb_cycle(logic wr, logic [31:0] data, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(4 * int'(REG_CAPACITY));
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_capacity(int unsigned raw);
    logic [31:0] rd;
    apb_cycle(1'b1, raw, rd);
    sb.set_capacity(raw);
    cfg_writes++;
    // the bus idles between the write and the read transfer
    @(posedge clk);
    apb_cycle(1'b0, '0, rd);
    sb.check_capacity(rd);
  endtask

  // a put leaves no result, so give the last one time to land
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: random stall per beat, plus one long hold-off on request
  initial begin
    int unsigned n;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      n = receiver_gaps ? $urandom_range(0, 3) : 0;
      if (hold_request) begin
        hold_request = 1'b0;
        n = HOLD_CYCLES;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_read(out_data);
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("lru_key_value_cache_unit test failed");
    $finish;
  end

  initial begin
    int unsigned raw_caps[10] = '{16, 1, 0, 31, 7, 3, 12, 2, 16, 5};
    int unsigned pool_n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes of key and value at the reset capacity
    send_access(mk(OP_GET, 32'h0, 32'h0));
    send_access(mk(OP_PUT, 32'h8000_0000, 32'h7fff_ffff));
    send_access(mk(OP_PUT, 32'h7fff_ffff, 32'h8000_0000));
    send_access(mk(OP_PUT, 32'h0, 32'h0));
    send_access(mk(OP_PUT, 32'hffff_ffff, 32'hffff_ffff));
    // hit whose value looks like a miss
    send_access(mk(OP_GET, 32'hffff_ffff, 32'h1234_5678));
    send_access(mk(OP_GET, 32'h8000_0000, 32'hffff_ffff));
    send_access(mk(OP_GET, 32'h5, 32'h0));
    send_access(mk(OP_PUT, 32'h7fff_ffff, 32'h0000_007b));
    send_access(mk(OP_GET, 32'h7fff_ffff, 32'hdead_beef));
    send_access(mk(OP_GET, 32'h0, 32'h0));
    in_valid <= 1'b0;
    settle();

    // shrink below the fill: least recent entries vanish at once
    write_capacity(2);
    send_access(mk(OP_GET, 32'hffff_ffff, 32'h0));
    send_access(mk(OP_GET, 32'h0, 32'h0));
    send_access(mk(OP_PUT, 32'h0000_00aa, 32'h5555_5555));
    send_access(mk(OP_GET, 32'h7fff_ffff, 32'h0));
    send_access(mk(OP_GET, 32'h0000_00aa, 32'h0));
    in_valid <= 1'b0;
    settle();

    // zero acts as a single entry
    write_capacity(0);
    send_access(mk(OP_PUT, 32'h1, 32'haaaa_aaaa));
    send_access(mk(OP_PUT, 32'h2, 32'h5555_5555));
    send_access(mk(OP_GET, 32'h1, 32'h0));
    send_access(mk(OP_GET, 32'h2, 32'h0));
    in_valid <= 1'b0;
    settle();

    for (int p = 0; p < 10; p++) begin
      write_capacity(raw_caps[p]);
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[$urandom_range(0, POOL_SIZE - 1)] = 32'h8000_0000;
      key_pool[$urandom_range(0, POOL_SIZE - 1)] = 32'h7fff_ffff;
      pool_n = sb.cap + $urandom_range(1, sb.cap + 2);
      sender_gaps   = (p != 3);
      receiver_gaps = (p != 3);
      if (p == 8) hold_request = 1'b1;
      repeat (PHASE_ITEMS) send_access(rand_access(pool_n));
      in_valid <= 1'b0;
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d accesses: %0d gets checked, %0d hits, %0d evictions",
             sb.accesses, sb.checked, sb.hits, sb.evictions);
    $display("%0d capacity writes incl. 0, 1, 16, 31 and shrinks below the fill",
             cfg_writes);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("lru_key_value_cache_unit test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.failures, sb.pending());
      $display("lru_key_value_cache_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_cell.sv
rtl/core/lru_key_value_cache_unit.sv
test/tb.sv
